// ===== hdl/csp_pkg.sv =====
`timescale 1ns / 1ps

package csp_pkg;

  localparam int VALUE_W  = 32;
  // bracket width: min - 1.0 and max both fit with a spare bit for the span
  localparam int BIS_W    = 34;
  localparam int WEIGHT_W = 17;

  localparam logic [WEIGHT_W-1:0] Q16_ONE = WEIGHT_W'(65536);

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // one closed vector handed from the loader to the solver
  typedef struct packed {
    logic                      bank;
    logic signed [VALUE_W-1:0] vmin;
    logic signed [VALUE_W-1:0] vmax;
    logic                      dropped;
  } csp_job_t;

endpackage

// ===== hdl/csp_if.sv =====
`timescale 1ns / 1ps

interface csp_in_if;
  import csp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface csp_out_if;
  import csp_pkg::*;

  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic                last_res;
  logic                overflow;

  modport source (output valid, output weight, output last_res, output overflow,
                  input ready);
  modport sink (input valid, input weight, input last_res, input overflow,
                output ready);
endinterface

// ===== hdl/csp_store.sv =====
`timescale 1ns / 1ps

module csp_store import csp_pkg::*; #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = 7
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ADDR_W-1:0]         waddr_i,
  input  logic signed [VALUE_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [ADDR_W-1:0]         raddr_i,
  output logic signed [VALUE_W-1:0] rdata_o
);

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/csp_queue.sv =====
`timescale 1ns / 1ps

module csp_queue import csp_pkg::*; #(
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  csp_job_t         push_job_i,
  input  logic [CNT_W-1:0] push_cnt_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output csp_job_t         head_job_o,
  output logic [CNT_W-1:0] head_cnt_o
);

  csp_job_t         job_q [2];
  logic [CNT_W-1:0] cnt_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       fill_q, fill_d;

  assign full_o     = (fill_q == 2'd2);
  assign valid_o    = (fill_q != 2'd0);
  assign head_job_o = job_q[rptr_q];
  assign head_cnt_o = cnt_q[rptr_q];

  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      job_q[wptr_q] <= push_job_i;
      cnt_q[wptr_q] <= push_cnt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      fill_q <= fill_d;
    end
  end

endmodule

// ===== hdl/csp_front.sv =====
`timescale 1ns / 1ps

module csp_front import csp_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 64,
  parameter int unsigned CNT_W        = 7,
  parameter int unsigned ADDR_W       = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  csp_in_if.sink                    in_i,
  output logic                      we_o,
  output logic [ADDR_W-1:0]         waddr_o,
  output logic signed [VALUE_W-1:0] wdata_o,
  output logic                      push_o,
  output csp_job_t                  push_job_o,
  output logic [CNT_W-1:0]          push_cnt_o,
  input  logic                      full_i
);

  localparam int unsigned IDX_W = ADDR_W - 1;

  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [VALUE_W-1:0] min_q, min_d, max_q, max_d;
  logic                      drop_q, drop_d;
  logic                      bank_q;
  logic                      accept, room;

  // a bank stays ours while the queue holds fewer than two closed vectors
  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign room       = (cnt_q != CNT_W'(MAX_ELEMENTS));

  assign we_o    = accept && room;
  assign waddr_o = {bank_q, cnt_q[IDX_W-1:0]};
  assign wdata_o = in_i.value;

  always_comb begin
    cnt_d  = cnt_q;
    min_d  = min_q;
    max_d  = max_q;
    drop_d = drop_q;
    if (accept) begin
      if (room) begin
        cnt_d = cnt_q + CNT_W'(1);
        if (in_i.value < min_q) min_d = in_i.value;
        if (in_i.value > max_q) max_d = in_i.value;
      end else begin
        drop_d = 1'b1;
      end
    end
  end

  assign push_o             = accept && in_i.last;
  assign push_job_o.bank    = bank_q;
  assign push_job_o.vmin    = min_d;
  assign push_job_o.vmax    = max_d;
  assign push_job_o.dropped = drop_d;
  assign push_cnt_o         = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      min_q  <= VALUE_MAX;
      max_q  <= VALUE_MIN;
      drop_q <= 1'b0;
      bank_q <= 1'b0;
    end else if (push_o) begin
      cnt_q  <= '0;
      min_q  <= VALUE_MAX;
      max_q  <= VALUE_MIN;
      drop_q <= 1'b0;
      bank_q <= ~bank_q;
    end else begin
      cnt_q  <= cnt_d;
      min_q  <= min_d;
      max_q  <= max_d;
      drop_q <= drop_d;
    end
  end

endmodule

// ===== hdl/csp_back.sv =====
`timescale 1ns / 1ps

module csp_back import csp_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS   = 64,
  parameter int unsigned MAX_ITERATIONS = 40,
  parameter int unsigned FRACTION_BITS  = 16,
  parameter int unsigned CNT_W          = 7,
  parameter int unsigned ADDR_W         = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  csp_job_t                  job_i,
  input  logic [CNT_W-1:0]          job_cnt_i,
  output logic                      pop_o,
  output logic                      re_o,
  output logic [ADDR_W-1:0]         raddr_o,
  input  logic signed [VALUE_W-1:0] rdata_i,
  csp_out_if.source                 out_o
);

  localparam int unsigned IDX_W  = ADDR_W - 1;
  localparam int unsigned ITER_W = $clog2(MAX_ITERATIONS + 1);
  localparam int unsigned TERM_W = FRACTION_BITS + 1;
  localparam int unsigned SUM_W  = FRACTION_BITS + 1 + $clog2(MAX_ELEMENTS);
  localparam int unsigned DIFF_W = BIS_W + 1;
  localparam int unsigned CONV_W = 33;
  localparam int unsigned SH_DN  = (FRACTION_BITS > 16) ? FRACTION_BITS - 16 : 0;
  localparam int unsigned SH_UP  = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;

  localparam logic [BIS_W-1:0]  ONE_BIS  = BIS_W'(1) << FRACTION_BITS;
  localparam logic [DIFF_W-1:0] ONE_DIFF = DIFF_W'(1) << FRACTION_BITS;
  localparam logic [TERM_W-1:0] ONE_TERM = TERM_W'(1) << FRACTION_BITS;
  localparam logic [SUM_W-1:0]  ONE_SUM  = SUM_W'(1) << FRACTION_BITS;
  localparam logic [CONV_W-1:0] ROUND    = CONV_W'((1 << SH_DN) >> 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_SWEEP  = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_EREAD  = 8'b0001_0000,
    S_EDATA  = 8'b0010_0000,
    S_ECONV  = 8'b0100_0000,
    S_EOUT   = 8'b1000_0000
  } state_e;

  state_e                  state_q, state_d;
  logic signed [BIS_W-1:0] lo_q, lo_d, hi_q, hi_d, tau_q, tau_d;
  logic [ITER_W-1:0]       iter_q, iter_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic                    rv_q, tv_q;
  logic [TERM_W-1:0]       term_q, term_d;
  logic                    ovalid_q, ovalid_d;
  logic [WEIGHT_W-1:0]     weight_q, weight_d;
  logic                    olast_q, olast_d;
  logic                    oflow_q, oflow_d;

  logic signed [BIS_W-1:0] span, mid;
  logic                    more;
  logic                    issue;
  logic [DIFF_W-1:0]       diff;
  logic [CONV_W-1:0]       conv;
  logic [WEIGHT_W-1:0]     weight_c;
  logic                    last_elem;

  // bracket midpoint, rounded toward minus infinity
  assign span = hi_q - lo_q;
  assign mid  = lo_q + (span >>> 1);
  assign more = (iter_q < ITER_W'(MAX_ITERATIONS)) && (span > BIS_W'(1));

  assign issue     = (state_q == S_SWEEP) && (idx_q != job_cnt_i);
  assign last_elem = (idx_q == job_cnt_i - CNT_W'(1));

  assign re_o    = issue || (state_q == S_EREAD);
  assign raddr_o = {job_i.bank, idx_q[IDX_W-1:0]};

  // clamp(v - tau, 0, 1.0)
  always_comb begin
    diff = DIFF_W'(rdata_i) - DIFF_W'(tau_q);
    diff = {{(DIFF_W-VALUE_W){rdata_i[VALUE_W-1]}}, rdata_i}
         - {tau_q[BIS_W-1], tau_q};
    if (diff[DIFF_W-1]) begin
      term_d = '0;
    end else if (diff > ONE_DIFF) begin
      term_d = ONE_TERM;
    end else begin
      term_d = diff[TERM_W-1:0];
    end
  end

  // rescale to q1.16, round half up when dropping bits
  always_comb begin
    conv = ((CONV_W'(term_q) + ROUND) >> SH_DN) << SH_UP;
    if (conv > CONV_W'(Q16_ONE)) begin
      weight_c = Q16_ONE;
    end else begin
      weight_c = conv[WEIGHT_W-1:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    tau_d    = tau_q;
    iter_d   = iter_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    ovalid_d = ovalid_q;
    weight_d = weight_q;
    olast_d  = olast_q;
    oflow_d  = oflow_q;
    pop_o    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          lo_d   = BIS_W'(job_i.vmin) - ONE_BIS;
          hi_d   = BIS_W'(job_i.vmax);
          iter_d = '0;
          idx_d  = '0;
          if (job_cnt_i == CNT_W'(1)) begin
            ovalid_d = 1'b1;
            weight_d = Q16_ONE;
            olast_d  = 1'b1;
            oflow_d  = job_i.dropped;
            state_d  = S_EOUT;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        tau_d = mid;
        idx_d = '0;
        sum_d = '0;
        state_d = more ? S_SWEEP : S_EREAD;
      end
      S_SWEEP: begin
        if (issue) begin
          idx_d = idx_q + CNT_W'(1);
        end
        if (tv_q) begin
          sum_d = sum_q + SUM_W'(term_q);
        end
        if (!issue && !rv_q && !tv_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sum_q > ONE_SUM) begin
          lo_d = tau_q;
        end else begin
          hi_d = tau_q;
        end
        iter_d  = iter_q + ITER_W'(1);
        state_d = S_CHECK;
      end
      S_EREAD: begin
        state_d = S_EDATA;
      end
      S_EDATA: begin
        state_d = S_ECONV;
      end
      S_ECONV: begin
        ovalid_d = 1'b1;
        weight_d = weight_c;
        olast_d  = last_elem;
        oflow_d  = job_i.dropped;
        state_d  = S_EOUT;
      end
      S_EOUT: begin
        if (out_o.ready) begin
          ovalid_d = 1'b0;
          if (last_elem) begin
            pop_o   = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_EREAD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_o.valid    = ovalid_q;
  assign out_o.weight   = weight_q;
  assign out_o.last_res = olast_q;
  assign out_o.overflow = oflow_q;

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    tau_q    <= tau_d;
    sum_q    <= sum_d;
    term_q   <= term_d;
    weight_q <= weight_d;
    olast_q  <= olast_d;
    oflow_q  <= oflow_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      iter_q   <= '0;
      idx_q    <= '0;
      rv_q     <= 1'b0;
      tv_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      iter_q   <= iter_d;
      idx_q    <= idx_d;
      rv_q     <= issue;
      tv_q     <= rv_q;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ===== hdl/capped_simplex_projection.sv =====
`timescale 1ns / 1ps

// channel  dir  beat payload                 accepted when
// in_i     in   value (s32 q16.16), last     in_i.valid && in_i.ready
// out_o    out  weight (u17 q1.16), last_res, out_o.valid && out_o.ready
//               overflow
//
// loading takes one element beat per cycle while in_i.ready is high, into one of two store banks
// per vector of n elements the solver runs up to MAX_ITERATIONS bisection steps,
// each a sweep over the single store read port, then steps through EREAD, EDATA,
// ECONV and EOUT per weight beat; a one-element vector answers 1.0 straight from idle
// in_i stalls only while one closed vector is being solved and a second waits
// reset is asynchronous, active low, and needs no clearing pass

module capped_simplex_projection import csp_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS   = 64,
  parameter int unsigned MAX_ITERATIONS = 40,
  parameter int unsigned FRACTION_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  csp_in_if.sink    in_i,
  csp_out_if.source out_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int unsigned ADDR_W = IDX_W + 1;

  logic                      we;
  logic [ADDR_W-1:0]         waddr;
  logic signed [VALUE_W-1:0] wdata;
  logic                      re;
  logic [ADDR_W-1:0]         raddr;
  logic signed [VALUE_W-1:0] rdata;
  logic                      push, full, pop, job_valid;
  csp_job_t                  push_job, head_job;
  logic [CNT_W-1:0]          push_cnt, head_cnt;

  csp_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .CNT_W        (CNT_W),
    .ADDR_W       (ADDR_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .push_o     (push),
    .push_job_o (push_job),
    .push_cnt_o (push_cnt),
    .full_i     (full)
  );

  // bank bit on top of the element index, so the store spans the full address range
  csp_store #(
    .DEPTH  (2 ** ADDR_W),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  csp_queue #(
    .CNT_W (CNT_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .push_cnt_i (push_cnt),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (job_valid),
    .head_job_o (head_job),
    .head_cnt_o (head_cnt)
  );

  csp_back #(
    .MAX_ELEMENTS   (MAX_ELEMENTS),
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .FRACTION_BITS  (FRACTION_BITS),
    .CNT_W          (CNT_W),
    .ADDR_W         (ADDR_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .job_cnt_i   (head_cnt),
    .pop_o       (pop),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .out_o       (out_o)
  );

endmodule
